// ===== hw/rtl/mmavg_pkg.sv =====
// ----------------------------------------------------------------------------
// mmavg_pkg
// Field widths, register indexes and reset values of the multichannel
// moving-average filter.
// ----------------------------------------------------------------------------
package mmavg_pkg;

  localparam int CHAN_W     = 2;
  localparam int SAMPLE_W   = 16;
  localparam int MV_W       = 20;
  localparam int HELD_W     = 5;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_MV = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE   = 1'b1;

  localparam logic [CFG_DATA_W-1:0] REF_MV_RESET     = 16'd2500;
  localparam logic [CFG_DATA_W-1:0] FULL_SCALE_RESET = 16'd32767;

  localparam logic [MV_W-1:0] MV_MAX = 20'hFFFFF;

endpackage

// ===== hw/rtl/mmavg_if.sv =====
// ----------------------------------------------------------------------------
// mmavg_if
// Valid/ready channels of the moving-average filter: sample requests in,
// filtered results out.
// ----------------------------------------------------------------------------
interface mmavg_in_if;
  logic                            valid;
  logic                            ready;
  logic [mmavg_pkg::CHAN_W-1:0]    channel;
  logic [mmavg_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mmavg_out_if;
  logic                            valid;
  logic                            ready;
  logic [mmavg_pkg::CHAN_W-1:0]    channel_out;
  logic [mmavg_pkg::SAMPLE_W-1:0]  average_code;
  logic [mmavg_pkg::MV_W-1:0]      millivolts_x16;
  logic                            window_full;
  logic [mmavg_pkg::HELD_W-1:0]    samples_held;

  modport source (output valid, output channel_out, output average_code,
                  output millivolts_x16, output window_full, output samples_held,
                  input ready);
  modport sink   (input valid, input channel_out, input average_code,
                  input millivolts_x16, input window_full, input samples_held,
                  output ready);
endinterface

// ===== hw/rtl/multichannel_moving_average_mv.sv =====
// ----------------------------------------------------------------------------
// multichannel_moving_average_mv
// Per-channel moving average over the last WINDOW samples, with the mean
// scaled to millivolts (4 fraction bits, saturating).
//
// in_chan takes one sample request tagged with its channel; a channel at or
// above CHANNELS is taken and dropped without a result. out_chan returns one
// result per kept request: channel, mean code, scaled millivolts, the
// window-full flag and the number of samples averaged.
// Each item is worked on by two bit-serial restoring dividers, and the next
// request is taken only once the last has left S_DONE: mean = sum / count
// over SUM_W steps (SUM_W = 16 + clog2(WINDOW)), with the reference multiply
// folded into it MSB first, then the scaled value over 20 steps divided by
// the full scale code. A saturated result skips the second division.
// The output register holds a result while the receiver stalls; the next
// request is still taken and worked on, and waits for the slot at its end.
// Synchronous reset clears all per-channel counts and sums and loads the
// configuration defaults; the sample history needs no clearing.
// Configuration writes go through cfg_we/cfg_index/cfg_wdata; the user is
// to make them only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module multichannel_moving_average_mv #(
  parameter int CHANNELS = 4,
  parameter int WINDOW   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  mmavg_in_if.sink                            in_chan,
  mmavg_out_if.source                         out_chan,
  input  logic                                cfg_we,
  input  logic [mmavg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mmavg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SUM_W   = mmavg_pkg::SAMPLE_W + $clog2(WINDOW);
  localparam int DEPTH   = CHANNELS * WINDOW;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW      = mmavg_pkg::SAMPLE_W;
  localparam int MV_W    = mmavg_pkg::MV_W;
  localparam int ACC_W   = 2 * SW;
  localparam int MAXSTEP = (SUM_W > MV_W) ? SUM_W : MV_W;
  localparam int STEP_W  = $clog2(MAXSTEP);

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_DIV1, S_CHK, S_DIV2, S_DONE
  } state_t;

  state_t state_r;

  // per-channel state
  logic [POS_W-1:0] wpos_r [CHANNELS];
  logic [CNT_W-1:0] fill_r [CHANNELS];
  logic [SUM_W-1:0] sum_r  [CHANNELS];
  logic             full_r [CHANNELS];

  logic [SW-1:0] ref_r;
  logic [SW-1:0] fs_r;

  // request being worked on
  logic [CH_W-1:0]   ch_r;
  logic [SW-1:0]     sample_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SW-1:0]     rd_data_r;
  logic [STEP_W-1:0] step_r;

  // mean divider with folded multiply
  logic [SUM_W-1:0]  num1_r;
  logic [CNT_W-1:0]  den1_r;
  logic [CNT_W-1:0]  rem1_r;
  logic [ACC_W-1:0]  acc_r;
  logic              flag_r;

  // millivolt divider
  logic [MV_W-1:0]   num2_r;
  logic [SW-1:0]     rem2_r;

  // output slot
  logic                              out_valid_r;
  logic [mmavg_pkg::CHAN_W-1:0]      out_ch_r;
  logic [SW-1:0]                     out_avg_r;
  logic [MV_W-1:0]                   out_mv_r;
  logic                              out_full_r;
  logic [mmavg_pkg::HELD_W-1:0]      out_held_r;

  // hidden history memory
  logic [SW-1:0] hist_mem [DEPTH];

  logic              in_fire;
  logic              ch_ok;
  logic [CH_W+1:0]   ch_ext;
  logic [CH_W-1:0]   in_ch_idx;
  logic [ADDR_W-1:0] rd_addr;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign ch_ok         = int'(in_chan.channel) < CHANNELS;
  assign ch_ext        = (CH_W + 2)'(in_chan.channel);
  assign in_ch_idx     = ch_ext[CH_W-1:0];
  assign rd_addr       = ADDR_W'(in_ch_idx) * ADDR_W'(WINDOW) + ADDR_W'(wpos_r[in_ch_idx]);

  // update step
  logic             was_full;
  logic [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0] fill_nxt;
  logic [POS_W-1:0] wpos_nxt;

  assign was_full = (fill_r[ch_r] == CNT_W'(WINDOW));
  assign sum_nxt  = sum_r[ch_r] - (was_full ? SUM_W'(rd_data_r) : '0) + SUM_W'(sample_r);
  assign fill_nxt = was_full ? fill_r[ch_r] : fill_r[ch_r] + 1'b1;
  assign wpos_nxt = (wpos_r[ch_r] == POS_W'(WINDOW - 1)) ? '0 : wpos_r[ch_r] + 1'b1;

  // one restoring step of each divider
  logic [CNT_W:0]   trial1;
  logic             ge1;
  logic [CNT_W-1:0] rem1_nxt;
  logic [ACC_W-1:0] acc_nxt;
  logic [SW:0]      trial2;
  logic             ge2;
  logic [SW-1:0]    rem2_nxt;

  assign trial1   = {rem1_r, num1_r[SUM_W-1]};
  assign ge1      = trial1 >= {1'b0, den1_r};
  assign rem1_nxt = ge1 ? CNT_W'(trial1 - {1'b0, den1_r}) : trial1[CNT_W-1:0];
  assign acc_nxt  = {acc_r[ACC_W-2:0], 1'b0} + (ge1 ? ACC_W'(ref_r) : '0);

  assign trial2   = {rem2_r, num2_r[MV_W-1]};
  assign ge2      = trial2 >= {1'b0, fs_r};
  assign rem2_nxt = ge2 ? SW'(trial2 - {1'b0, fs_r}) : trial2[SW-1:0];

  // scaled numerator is acc * 16: its top SW bits decide saturation
  logic sat;
  assign sat = acc_r[ACC_W-1:ACC_W-SW] >= fs_r;

  logic out_free;
  assign out_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (in_fire && ch_ok) begin
      rd_data_r <= hist_mem[rd_addr];
    end
    if (state_r == S_UPD) begin
      hist_mem[addr_r] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ref_r       <= mmavg_pkg::REF_MV_RESET;
      fs_r        <= mmavg_pkg::FULL_SCALE_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
        wpos_r[c] <= '0;
        fill_r[c] <= '0;
        sum_r[c]  <= '0;
        full_r[c] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mmavg_pkg::REG_REFERENCE_MV: ref_r <= cfg_wdata;
          mmavg_pkg::REG_FULL_SCALE:   fs_r  <= cfg_wdata;
          default: ;
        endcase
      end

      // in S_DONE the slot is refilled whenever it drains
      if (out_valid_r && out_chan.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          // drop requests for channels that do not exist
          if (in_fire && ch_ok) begin
            ch_r     <= in_ch_idx;
            sample_r <= in_chan.sample;
            addr_r   <= rd_addr;
            state_r  <= S_UPD;
          end
        end
        S_UPD: begin
          sum_r[ch_r]  <= sum_nxt;
          fill_r[ch_r] <= fill_nxt;
          wpos_r[ch_r] <= wpos_nxt;
          full_r[ch_r] <= full_r[ch_r] || (fill_nxt == CNT_W'(WINDOW));
          flag_r       <= full_r[ch_r] || (fill_nxt == CNT_W'(WINDOW));
          num1_r       <= sum_nxt;
          den1_r       <= fill_nxt;
          rem1_r       <= '0;
          acc_r        <= '0;
          step_r       <= '0;
          state_r      <= S_DIV1;
        end
        S_DIV1: begin
          num1_r <= {num1_r[SUM_W-2:0], ge1};
          rem1_r <= rem1_nxt;
          acc_r  <= acc_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(SUM_W - 1)) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          step_r <= '0;
          if (sat) begin
            num2_r  <= mmavg_pkg::MV_MAX;
            state_r <= S_DONE;
          end else begin
            rem2_r  <= acc_r[ACC_W-1:ACC_W-SW];
            num2_r  <= MV_W'({acc_r[ACC_W-SW-1:0], 4'b0000});
            state_r <= S_DIV2;
          end
        end
        S_DIV2: begin
          num2_r <= {num2_r[MV_W-2:0], ge2};
          rem2_r <= rem2_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(MV_W - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output slot frees up
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_ch_r    <= mmavg_pkg::CHAN_W'(ch_r);
            out_avg_r   <= num1_r[SW-1:0];
            out_mv_r    <= num2_r;
            out_full_r  <= flag_r;
            out_held_r  <= mmavg_pkg::HELD_W'(den1_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.channel_out    = out_ch_r;
  assign out_chan.average_code   = out_avg_r;
  assign out_chan.millivolts_x16 = out_mv_r;
  assign out_chan.window_full    = out_full_r;
  assign out_chan.samples_held   = out_held_r;

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (fill_r[ch_r] <= CNT_W'(WINDOW)))
    else $error("fill count above window");

  a_rem1_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV1) |-> (rem1_r < den1_r))
    else $error("mean divider remainder not below count");

  a_rem2_below_fs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV2) |-> (rem2_r < fs_r))
    else $error("millivolt divider remainder not below full scale");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_chan.ready) |=> (state_r == S_DONE))
    else $error("result overwrote a stalled output");

  a_drop_bad_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !ch_ok) |=> (state_r == S_IDLE))
    else $error("request for missing channel was processed");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multichannel moving-average filter. Drives
// sample requests and scaling writes, predicts each channel's mean, scaled
// millivolts, fill count and window flag, and compares every result in order.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [mmavg_pkg::CHAN_W-1:0]   channel;
  logic [mmavg_pkg::SAMPLE_W-1:0] average;
  logic [mmavg_pkg::MV_W-1:0]     millivolts;
  logic                           full;
  logic [mmavg_pkg::HELD_W-1:0]   held;
} mean_result_t;

class mean_scoreboard #(int CHANNELS = 4, int WINDOW = 16);
  logic [mmavg_pkg::SAMPLE_W-1:0]   ring [CHANNELS][WINDOW];
  int unsigned                      wpos [CHANNELS];
  int unsigned                      fill [CHANNELS];
  int unsigned                      total [CHANNELS];
  bit                               full [CHANNELS];
  logic [mmavg_pkg::CFG_DATA_W-1:0] ref_mv;
  logic [mmavg_pkg::CFG_DATA_W-1:0] full_scale;
  mean_result_t                     expected_means [$];
  int                               errors;
  int                               checked;

  function new();
    for (int c = 0; c < CHANNELS; c++) begin
      wpos[c]  = 0;
      fill[c]  = 0;
      total[c] = 0;
      full[c]  = 1'b0;
    end
    ref_mv     = mmavg_pkg::REF_MV_RESET;
    full_scale = mmavg_pkg::FULL_SCALE_RESET;
    errors     = 0;
    checked    = 0;
  endfunction

  function void set_scaling(logic [mmavg_pkg::CFG_IDX_W-1:0] idx,
                            logic [mmavg_pkg::CFG_DATA_W-1:0] value);
    if (idx == mmavg_pkg::REG_REFERENCE_MV)
      ref_mv = value;
    else if (idx == mmavg_pkg::REG_FULL_SCALE)
      full_scale = value;
  endfunction

  function int pending();
    return expected_means.size();
  endfunction

  function void note_sample(logic [mmavg_pkg::CHAN_W-1:0] ch,
                            logic [mmavg_pkg::SAMPLE_W-1:0] smp);
    int unsigned       pos;
    int unsigned       mean;
    longint unsigned   scaled;
    mean_result_t      r;
    // drop requests for channels the block does not have
    if (ch >= CHANNELS)
      return;
    pos = wpos[ch];
    if (pos >= WINDOW)
      pos = 0;
    // retire the oldest sample only once the ring has wrapped
    if (fill[ch] >= WINDOW)
      total[ch] -= ring[ch][pos];
    total[ch] += smp;
    ring[ch][pos] = smp;
    pos++;
    if (pos >= WINDOW)
      pos = 0;
    wpos[ch] = pos;
    if (fill[ch] < WINDOW)
      fill[ch]++;
    if (fill[ch] >= WINDOW)
      full[ch] = 1'b1;
    mean = total[ch] / fill[ch];
    if (full_scale == '0) begin
      r.millivolts = mmavg_pkg::MV_MAX;
    end else begin
      scaled = longint'(mean[15:0]) * ref_mv * 16 / full_scale;
      r.millivolts = (scaled > mmavg_pkg::MV_MAX) ? mmavg_pkg::MV_MAX : scaled[19:0];
    end
    r.channel = ch;
    r.average = mean[15:0];
    r.full    = full[ch];
    r.held    = fill[ch][mmavg_pkg::HELD_W-1:0];
    expected_means.push_back(r);
  endfunction

  function void report(string field, longint unsigned want, longint unsigned got);
    errors++;
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
  endfunction

  function void check_result(mean_result_t got);
    mean_result_t want;
    if (expected_means.size() == 0) begin
      errors++;
      $display("%0t: result with none expected, expected nothing actual channel %0d mean %0d",
               $time, got.channel, got.average);
      return;
    end
    want = expected_means.pop_front();
    checked++;
    if (got.channel !== want.channel)
      report("channel_out", want.channel, got.channel);
    if (got.average !== want.average)
      report("average_code", want.average, got.average);
    if (got.millivolts !== want.millivolts)
      report("millivolts_x16", want.millivolts, got.millivolts);
    if (got.full !== want.full)
      report("window_full", want.full, got.full);
    if (got.held !== want.held)
      report("samples_held", want.held, got.held);
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS      = 4;
  localparam int WINDOW        = 16;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 225;
  localparam int SETTLE_CYCLES = 100;
  localparam int PRESSURE_AT   = 400;
  localparam int HOLD_CYCLES   = 800;
  localparam int STALL_LIMIT   = 5000;

  logic clk;
  logic rst_n;
  logic                             cfg_we;
  logic [mmavg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mmavg_pkg::CFG_DATA_W-1:0] cfg_wdata;
  bit   steady;
  int   quiet_cycles;

  mmavg_in_if  in_if ();
  mmavg_out_if out_if ();

  mean_scoreboard #(CHANNELS, WINDOW) sb;

  multichannel_moving_average_mv #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Handshake monitor, result check and no-progress watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_sample(in_if.channel, in_if.sample);
      if (out_if.valid && out_if.ready)
        sb.check_result('{out_if.channel_out, out_if.average_code, out_if.millivolts_x16,
                          out_if.window_full, out_if.samples_held});
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result receiver: random back-pressure plus one long hold-off
  initial begin : receiver
    int hold_left;
    bit pressed;
    hold_left = 0;
    pressed   = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressed && sb != null && sb.checked >= PRESSURE_AT) begin
        pressed   = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady || ($urandom_range(99) >= 32);
      end
    end
  end

  task automatic offer_sample(input logic [mmavg_pkg::CHAN_W-1:0] ch,
                              input logic [mmavg_pkg::SAMPLE_W-1:0] smp);
    @(negedge clk);
    if (!steady) begin
      // occasional long gap so requests land on every step of the divider
      if ($urandom_range(99) < 4) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(60, 1)) @(negedge clk);
      end
      while ($urandom_range(99) < 32) begin
        in_if.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_if.valid   <= 1'b1;
    in_if.channel <= ch;
    in_if.sample  <= smp;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic wait_until_settled();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_scaling(input logic [mmavg_pkg::CFG_DATA_W-1:0] ref_value,
                              input logic [mmavg_pkg::CFG_DATA_W-1:0] fs_value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= mmavg_pkg::REG_REFERENCE_MV;
    cfg_wdata <= ref_value;
    sb.set_scaling(mmavg_pkg::REG_REFERENCE_MV, ref_value);
    @(negedge clk);
    cfg_index <= mmavg_pkg::REG_FULL_SCALE;
    cfg_wdata <= fs_value;
    sb.set_scaling(mmavg_pkg::REG_FULL_SCALE, fs_value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [mmavg_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return mmavg_pkg::SAMPLE_W'($urandom_range(65535, 65000));
      3:       return mmavg_pkg::SAMPLE_W'($urandom_range(500));
      default: return mmavg_pkg::SAMPLE_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [mmavg_pkg::CFG_DATA_W-1:0] ref_value;
    logic [mmavg_pkg::CFG_DATA_W-1:0] fs_value;
    sb            = new();
    clk           = 1'b0;
    rst_n         = 1'b0;
    steady        = 1'b0;
    quiet_cycles  = 0;
    cfg_we        = 1'b0;
    cfg_index     = mmavg_pkg::REG_REFERENCE_MV;
    cfg_wdata     = '0;
    in_if.valid   = 1'b0;
    in_if.channel = '0;
    in_if.sample  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Field extremes, window wrap with a full-scale sum, warm-up divisors
    offer_sample(2'd0, 16'h0000);
    offer_sample(2'd0, 16'hFFFF);
    offer_sample(2'd3, 16'h0000);
    offer_sample(2'd2, 16'h0001);
    offer_sample(2'd2, 16'h0002);
    repeat (WINDOW + 1) offer_sample(2'd1, 16'hFFFF);
    offer_sample(2'd0, 16'h7FFF);
    // scaled value too large
    wait_until_settled();
    load_scaling(16'hFFFF, 16'd1);
    offer_sample(2'd0, 16'hFFFF);
    // zero full scale saturates
    wait_until_settled();
    load_scaling(16'hFFFF, 16'd0);
    offer_sample(2'd2, 16'h1234);

    for (int p = 0; p < PHASES; p++) begin
      wait_until_settled();
      case (p)
        0: begin
          ref_value = mmavg_pkg::REF_MV_RESET;
          fs_value  = mmavg_pkg::FULL_SCALE_RESET;
        end
        1: begin ref_value = 16'hFFFF;     fs_value = 16'hFFFF;         end
        2: begin ref_value = 16'd1;        fs_value = 16'hFFFF;         end
        3: begin ref_value = 16'hFFFF;     fs_value = 16'd1;            end
        4: begin ref_value = 16'd0;        fs_value = mmavg_pkg::FULL_SCALE_RESET; end
        5: begin ref_value = 16'd1;        fs_value = 16'd1;            end
        6: begin
          ref_value = mmavg_pkg::CFG_DATA_W'($urandom());
          fs_value  = mmavg_pkg::CFG_DATA_W'($urandom_range(65535, 1));
        end
        default: begin
          ref_value = mmavg_pkg::CFG_DATA_W'($urandom());
          fs_value  = mmavg_pkg::CFG_DATA_W'($urandom_range(3));
        end
      endcase
      // first phase runs both sides at full rate
      steady = (p == 0);
      load_scaling(ref_value, fs_value);
      repeat (PHASE_ITEMS)
        offer_sample(mmavg_pkg::CHAN_W'($urandom_range(CHANNELS - 1)), pick_sample());
    end

    wait_until_settled();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
